// File: src/c_escape_string_decoder_unit_defines.svh
// assertion macros shared by the escape decoder modules
`ifndef C_ESCAPE_STRING_DECODER_UNIT_DEFINES_SVH
`define C_ESCAPE_STRING_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define CED_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ced assertion failed");

// next-cycle implication, held off while reset is asserted
`define CED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ced assertion failed");

`endif

// File: src/ced_pkg.sv
// types, character codes and helpers for the escape string decoder
package ced_pkg;

    // command queue between front and back
    localparam int C_QDEPTH = 4;
    localparam int C_QPTR_W = $clog2(C_QDEPTH);
    localparam int C_QCNT_W = $clog2(C_QDEPTH + 1);

    // character codes
    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_VT     = 8'h0B;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_QMARK  = 8'h3F;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_CH_0   = 8'h30;
    localparam logic [7:0] C_CH_7   = 8'h37;
    localparam logic [7:0] C_CH_9   = 8'h39;
    localparam logic [7:0] C_UC_A   = 8'h41;
    localparam logic [7:0] C_UC_F   = 8'h46;
    localparam logic [7:0] C_LC_A   = 8'h61;
    localparam logic [7:0] C_LC_F   = 8'h66;
    localparam logic [7:0] C_LC_N   = 8'h6E;
    localparam logic [7:0] C_LC_R   = 8'h72;
    localparam logic [7:0] C_LC_T   = 8'h74;
    localparam logic [7:0] C_LC_V   = 8'h76;
    localparam logic [7:0] C_LC_X   = 8'h78;

    // decoder mode, one-hot
    typedef enum logic [5:0] {
        M_SKIP = 6'b000001,
        M_TEXT = 6'b000010,
        M_ESC  = 6'b000100,
        M_OCT  = 6'b001000,
        M_HEX  = 6'b010000,
        M_DONE = 6'b100000
    } t_mode;

    // one queued transaction group: one or two output bytes
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_cmd;

    // hex digit decode: {is_digit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'b0;
        if (c >= C_CH_0 && c <= C_CH_9) begin
            res = {1'b1, 4'(c - C_CH_0)};
        end else if (c >= C_UC_A && c <= C_UC_F) begin
            res = {1'b1, 4'(c - C_UC_A + 8'd10)};
        end else if (c >= C_LC_A && c <= C_LC_F) begin
            res = {1'b1, 4'(c - C_LC_A + 8'd10)};
        end
        return res;
    endfunction

endpackage

// File: src/ced_front.sv
// front end: mode tracking and escape classification, one byte per cycle while the queue is not full
`include "c_escape_string_decoder_unit_defines.svh"

module ced_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_ch,
    input  logic          i_full,
    output logic          o_stall,
    output logic          o_push,
    output ced_pkg::t_cmd o_cmd
);

    ced_pkg::t_mode r_mode, n_mode;
    logic [7:0]     r_accum, n_accum;

    logic           acc;
    ced_pkg::t_mode txt_mode;
    logic           txt_emit;
    logic           use_txt;
    logic           pre_valid;
    logic [7:0]     pre_byte;
    logic           pre_put;
    logic           txt_put;
    logic [4:0]     hex;
    logic           is_oct;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;
    assign hex     = ced_pkg::hex_digit(i_ch);
    assign is_oct  = (i_ch >= ced_pkg::C_CH_0) && (i_ch <= ced_pkg::C_CH_7);

    // byte handled as plain literal text
    always_comb begin
        txt_emit = 1'b0;
        if (i_ch == ced_pkg::C_NUL) begin
            txt_mode = ced_pkg::M_SKIP;
        end else if (i_ch == ced_pkg::C_DQUOTE) begin
            txt_mode = ced_pkg::M_DONE;
        end else if (i_ch == ced_pkg::C_BSLASH) begin
            txt_mode = ced_pkg::M_ESC;
        end else begin
            txt_mode = ced_pkg::M_TEXT;
            txt_emit = 1'b1;
        end
    end

    // mode decode and run accumulation
    always_comb begin
        n_mode    = r_mode;
        n_accum   = r_accum;
        pre_valid = 1'b0;
        pre_byte  = r_accum;
        use_txt   = 1'b0;
        unique case (r_mode)
            ced_pkg::M_SKIP: begin
                if (i_ch != ced_pkg::C_NUL) n_mode = ced_pkg::M_TEXT;
            end
            ced_pkg::M_TEXT: begin
                use_txt = 1'b1;
                n_mode  = txt_mode;
            end
            ced_pkg::M_ESC: begin
                n_mode    = ced_pkg::M_TEXT;
                pre_valid = 1'b1;
                unique case (i_ch) inside
                    ced_pkg::C_BSLASH: pre_byte = ced_pkg::C_BSLASH;
                    ced_pkg::C_LC_N:   pre_byte = ced_pkg::C_LF;
                    ced_pkg::C_LC_T:   pre_byte = ced_pkg::C_TAB;
                    ced_pkg::C_LC_V:   pre_byte = ced_pkg::C_VT;
                    ced_pkg::C_LC_R:   pre_byte = ced_pkg::C_CR;
                    ced_pkg::C_SQUOTE: pre_byte = ced_pkg::C_SQUOTE;
                    ced_pkg::C_DQUOTE: pre_byte = ced_pkg::C_DQUOTE;
                    ced_pkg::C_QMARK:  pre_byte = ced_pkg::C_QMARK;
                    ced_pkg::C_LC_X: begin
                        pre_valid = 1'b0;
                        n_accum   = 8'd0;
                        n_mode    = ced_pkg::M_HEX;
                    end
                    [ced_pkg::C_CH_0:ced_pkg::C_CH_7]: begin
                        pre_valid = 1'b0;
                        n_accum   = {5'b0, i_ch[2:0]};
                        n_mode    = ced_pkg::M_OCT;
                    end
                    default: begin
                        // unknown escape: backslash, then the byte as text
                        pre_byte = ced_pkg::C_BSLASH;
                        use_txt  = 1'b1;
                        n_mode   = txt_mode;
                    end
                endcase
            end
            ced_pkg::M_OCT: begin
                if (is_oct) begin
                    n_accum = {r_accum[4:0], i_ch[2:0]};
                end else begin
                    pre_valid = 1'b1;
                    use_txt   = 1'b1;
                    n_mode    = txt_mode;
                end
            end
            ced_pkg::M_HEX: begin
                if (hex[4]) begin
                    n_accum = {r_accum[3:0], hex[3:0]};
                end else begin
                    pre_valid = 1'b1;
                    use_txt   = 1'b1;
                    n_mode    = txt_mode;
                end
            end
            default: begin
                // literal ended: wait for nul
                if (i_ch == ced_pkg::C_NUL) n_mode = ced_pkg::M_SKIP;
            end
        endcase
    end

    // pack up to two non-zero bytes
    assign pre_put    = pre_valid && (pre_byte != ced_pkg::C_NUL);
    assign txt_put    = use_txt && txt_emit;
    assign o_push     = acc && (pre_put || txt_put);
    assign o_cmd.two  = pre_put && txt_put;
    assign o_cmd.b0   = pre_put ? pre_byte : i_ch;
    assign o_cmd.b1   = i_ch;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ced_pkg::M_SKIP;
            r_accum <= 8'd0;
        end else if (acc) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
        end
    end

    `CED_ASSERT_NEXT(a_nul_rearms, i_clk, i_rst_n, acc && (i_ch == ced_pkg::C_NUL), r_mode == ced_pkg::M_SKIP)
    `CED_ASSERT_NOW(a_push_nonzero, i_clk, i_rst_n, o_push, o_cmd.b0 != ced_pkg::C_NUL)
    `CED_ASSERT_NOW(a_two_nonzero, i_clk, i_rst_n, o_push && o_cmd.two, o_cmd.b1 != ced_pkg::C_NUL)

endmodule

// File: src/ced_queue.sv
// small command queue between front and back end
`include "c_escape_string_decoder_unit_defines.svh"

module ced_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ced_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output ced_pkg::t_cmd o_head,
    output logic          o_nempty,
    output logic          o_full
);

    ced_pkg::t_cmd                 r_slot [ced_pkg::C_QDEPTH];
    logic [ced_pkg::C_QPTR_W-1:0]  r_wptr;
    logic [ced_pkg::C_QPTR_W-1:0]  r_rptr;
    logic [ced_pkg::C_QCNT_W-1:0]  r_count, n_count;

    assign o_head   = r_slot[r_rptr];
    assign o_nempty = (r_count != '0);
    assign o_full   = (r_count == ced_pkg::C_QCNT_W'(ced_pkg::C_QDEPTH));

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop) r_rptr <= r_rptr + 1'b1;
            r_count <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wptr] <= i_cmd;
    end

    `CED_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `CED_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, o_nempty)
    `CED_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= ced_pkg::C_QCNT_W'(ced_pkg::C_QDEPTH))

endmodule

// File: src/ced_back.sv
// back end: splits queued commands into single output bytes
`include "c_escape_string_decoder_unit_defines.svh"

module ced_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ced_pkg::t_cmd i_head,
    input  logic          i_nempty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_byte,
    output logic          o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_phase;
    logic       load;
    logic       split;

    assign load    = !r_valid || !i_stall;
    assign split   = i_head.two && !r_phase;
    assign o_pop   = load && i_nempty && !split;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= i_nempty;
            if (i_nempty) r_phase <= split;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load && i_nempty) begin
            r_byte <= (r_phase && i_head.two) ? i_head.b1 : i_head.b0;
            r_last <= !split;
        end
    end

    `CED_ASSERT_NOW(a_out_nonzero, i_clk, i_rst_n, r_valid, r_byte != ced_pkg::C_NUL)
    `CED_ASSERT_NOW(a_phase_first, i_clk, i_rst_n, r_phase, r_valid && !r_last)
    `CED_ASSERT_NEXT(a_phase_follow, i_clk, i_rst_n, r_phase && load, r_valid && r_last)

endmodule

// File: src/c_escape_string_decoder_unit.sv
// top level: decodes a quoted c string literal into output bytes
// throughput: one input byte per cycle while the queue is not full; one output byte per cycle
//   while the output is not stalled, so inputs that yield two bytes are absorbed by a 4-entry queue
// reset: synchronous active-low; the decoder re-arms to skip the opening quote
//   and the queue and output register empty
module c_escape_string_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_ch,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic          push;
    logic          pop;
    logic          nempty;
    logic          full;
    ced_pkg::t_cmd cmd;
    ced_pkg::t_cmd head;

    // classification and mode tracking
    ced_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_ch    (i_ch),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    // decoupling queue
    ced_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_nempty (nempty),
        .o_full   (full)
    );

    // byte emission
    ced_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_nempty (nempty),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_byte   (o_out_byte),
        .o_last   (o_last_of_run)
    );

endmodule
